/* rtl/lci_pkg.sv */
// ----------------------------------------------------------------------------
// lci_pkg
// Shared widths, status codes and cell payload types for the line / circle
// intersection pipeline.
// ----------------------------------------------------------------------------
package lci_pkg;

	localparam int FRAC_BITS = 12;
	localparam int WORD_BITS = 24;

	// magnitude of a line coefficient, including the most negative value
	localparam int MAG_W = WORD_BITS;
	// a^2 + b^2
	localparam int Q_W = 2 * WORD_BITS;
	// centre-relative line offset k, signed
	localparam int K_W = 2 * WORD_BITS + 2;
	// radius squared
	localparam int R2_W = 2 * (WORD_BITS - 1);
	// square root result and its radicand
	localparam int S_W = 2 * WORD_BITS;
	localparam int E_W = 2 * S_W;
	localparam int REM_W = S_W + 2;
	// numerator magnitude and signed numerator
	localparam int NM_W = 3 * WORD_BITS + 2;
	localparam int N_W = NM_W + 2;
	// wide multiplier operands, halves and product
	localparam int OP_W = K_W;
	localparam int OH_W = OP_W / 2;
	localparam int P_W = 2 * OP_W;

	localparam int SQRT_CELLS = S_W;
	localparam int DIV_CELLS = NM_W;
	localparam int LANES = 4;

	localparam int IN_W = 6 * WORD_BITS;
	localparam int OUT_W = 4 * WORD_BITS;

	localparam logic [1:0] ST_HIT = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;

	// item state inside the square root chain
	typedef struct packed {
		logic                        valid;
		logic [1:0]                  status;
		logic [E_W-1:0]              e;
		logic [REM_W-1:0]            rem;
		logic [S_W-1:0]              root;
		logic signed [N_W-1:0]       tv;
		logic signed [N_W-1:0]       tu;
		logic [MAG_W-1:0]            ma;
		logic [MAG_W-1:0]            mb;
		logic                        fneg;
		logic [Q_W-1:0]              q;
		logic signed [WORD_BITS-1:0] cx;
		logic signed [WORD_BITS-1:0] cy;
	} sq_t;

	// one division lane
	typedef struct packed {
		logic            neg;
		logic [NM_W-1:0] num;
		logic [Q_W-1:0]  rem;
		logic [NM_W-1:0] quot;
	} dl_t;

	// item state inside the division chain
	typedef struct packed {
		logic                        valid;
		logic [1:0]                  status;
		logic [Q_W-1:0]              q;
		logic signed [WORD_BITS-1:0] cx;
		logic signed [WORD_BITS-1:0] cy;
		dl_t [LANES-1:0]             lane;
	} dv_t;

endpackage

/* rtl/lci_mul.sv */
// ----------------------------------------------------------------------------
// lci_mul
// Two-stage unsigned wide multiplier built from four half-width products.
// ----------------------------------------------------------------------------
module lci_mul (
	input  logic                     clk,
	input  logic                     en,
	input  logic [lci_pkg::OP_W-1:0] x,
	input  logic [lci_pkg::OP_W-1:0] y,
	output logic [lci_pkg::P_W-1:0]  p
);
	localparam int OH = lci_pkg::OH_W;
	localparam int PW = lci_pkg::P_W;

	logic [2*OH-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [PW-1:0]   p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= x[OH-1:0] * y[OH-1:0];
			lh_s1 <= x[OH-1:0] * y[2*OH-1:OH];
			hl_s1 <= x[2*OH-1:OH] * y[OH-1:0];
			hh_s1 <= x[2*OH-1:OH] * y[2*OH-1:OH];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= PW'(ll_s1) + (PW'(lh_s1) << OH) + (PW'(hl_s1) << OH)
				+ (PW'(hh_s1) << (2 * OH));
		end
	end

	assign p = p_s2;

endmodule

/* rtl/lci_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// lci_sqrt_cell
// One digit of the restoring integer square root; carries the item along.
// ----------------------------------------------------------------------------
module lci_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  lci_pkg::sq_t  d,
	output lci_pkg::sq_t  q_o
);
	localparam int RW = lci_pkg::REM_W;
	localparam int SW = lci_pkg::S_W;
	localparam int EW = lci_pkg::E_W;

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          fit;
	lci_pkg::sq_t  nx;
	lci_pkg::sq_t  pay_q;
	logic          valid_q;

	always_comb begin
		rem_sh = {d.rem, d.e[EW-1 -: 2]};
		trial = {{(RW - SW){1'b0}}, d.root, 2'b01};
		fit = rem_sh >= trial;
		nx = d;
		nx.e = {d.e[EW-3:0], 2'b00};
		nx.rem = fit ? RW'(rem_sh - trial) : RW'(rem_sh);
		nx.root = {d.root[SW-2:0], fit};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_comb begin
		q_o = pay_q;
		q_o.valid = valid_q;
	end

endmodule

/* rtl/lci_div_cell.sv */
// ----------------------------------------------------------------------------
// lci_div_cell
// One quotient bit of four restoring divisions by the same divisor.
// ----------------------------------------------------------------------------
module lci_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  lci_pkg::dv_t  d,
	output lci_pkg::dv_t  q_o
);
	localparam int QW = lci_pkg::Q_W;
	localparam int NW = lci_pkg::NM_W;

	logic [QW:0]  sh [lci_pkg::LANES];
	logic         fit [lci_pkg::LANES];
	lci_pkg::dv_t nx;
	lci_pkg::dv_t pay_q;
	logic         valid_q;

	always_comb begin
		nx = d;
		for (int i = 0; i < lci_pkg::LANES; i++) begin
			sh[i] = {d.lane[i].rem, d.lane[i].num[NW-1]};
			fit[i] = sh[i] >= {1'b0, d.q};
			nx.lane[i].num = {d.lane[i].num[NW-2:0], 1'b0};
			nx.lane[i].rem = fit[i] ? QW'(sh[i] - {1'b0, d.q}) : QW'(sh[i]);
			nx.lane[i].quot = {d.lane[i].quot[NW-2:0], fit[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_comb begin
		q_o = pay_q;
		q_o.valid = valid_q;
	end

endmodule

/* rtl/line_circle_intersection_unit.sv */
// ----------------------------------------------------------------------------
// line_circle_intersection_unit
// Intersection points of a line a*x+b*y+c=0 and a circle, signed Q12.12.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one query per transfer (line, centre, radius);
//   the master stream returns one result per transfer: a status in tuser and
//   both points in tdata. Status hit gives the two roots, saturated to the
//   word range; miss and degenerate line give all coordinates zero.
//   The block is a fully pipelined row of cells: front-end products, split
//   wide multipliers, one square root cell per root bit (48) and one divide
//   cell per quotient bit (74), four divisions sharing each cell.
//   Throughput is one transfer per cycle while the receiver does not stall.
//   Reset clears every valid bit in the pipeline; no results are pending
//   after reset. When the receiver stalls with a result waiting in the
//   output register, the whole pipeline holds and tready drops; it accepts
//   again in the cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module line_circle_intersection_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// line_a, line_b, line_offset, centre_x, centre_y, radius, zero pad
	input  logic [lci_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// first_x, first_y, second_x, second_y
	output logic [lci_pkg::OUT_W-1:0] m_tdata,
	// status
	output logic [1:0]                m_tuser
);
	localparam int W = lci_pkg::WORD_BITS;
	localparam int MW = lci_pkg::MAG_W;
	localparam int KW = lci_pkg::K_W;
	localparam int QW = lci_pkg::Q_W;
	localparam int R2W = lci_pkg::R2_W;
	localparam int OPW = lci_pkg::OP_W;
	localparam int PW = lci_pkg::P_W;
	localparam int EW = lci_pkg::E_W;
	localparam int NW = lci_pkg::N_W;
	localparam int NMW = lci_pkg::NM_W;
	localparam int SUMW = W + 4;

	typedef struct packed {
		logic [MW-1:0]       ma;
		logic [MW-1:0]       mb;
		logic                an;
		logic                az;
		logic                bn;
		logic                bp;
		logic                kn;
		logic [QW-1:0]       q;
		logic signed [W-1:0] cx;
		logic signed [W-1:0] cy;
	} side_t;

	logic en;

	// input unpack
	logic signed [W-1:0] in_a, in_b, in_c, in_cx, in_cy;
	logic [W-2:0]        in_r;
	logic [MW-1:0]       in_ma, in_mb;

	// stage 1
	logic                  v_s1;
	logic signed [2*W-1:0] pac_s1, pbc_s1;
	logic [2*MW-1:0]       sqa_s1, sqb_s1;
	logic [R2W-1:0]        r2_s1;
	logic signed [W-1:0]   c_s1, cx_s1, cy_s1;
	logic [MW-1:0]         ma_s1, mb_s1;
	logic                  an_s1, az_s1, bn_s1, bp_s1;

	// stage 2 and the wide multipliers
	logic                  v_s2, v_s3, v_s4;
	logic signed [KW-1:0]  k_s2;
	logic [R2W-1:0]        r2_s2;
	side_t                 side_s2, side_s3, side_s4;
	side_t                 side_k;
	logic [KW-2:0]         km;
	logic [PW-1:0]         k2_p, qr2_p, bk_p, ak_p;

	// square root chain
	logic [PW-1:0]         diff;
	logic                  miss, degen, gpos;
	logic [NW-1:0]         tvm, tum;
	logic                  v_s5, v_s6, v_s7, v_s8;
	lci_pkg::sq_t          sq_in, sq_s5;
	lci_pkg::sq_t          sqc [lci_pkg::SQRT_CELLS+1];
	lci_pkg::sq_t          sq_s6, sq_s7;
	logic [PW-1:0]         as_p, bs_p;

	// division chain
	logic signed [NW-1:0]  as_v, bs_v;
	logic signed [NW-1:0]  nl [lci_pkg::LANES];
	logic signed [NW-1:0]  nabs [lci_pkg::LANES];
	lci_pkg::dv_t          dv_in, dv_s8;
	lci_pkg::dv_t          dvc [lci_pkg::DIV_CELLS+1];

	// output
	logic [NMW-1:0]        mag [lci_pkg::LANES];
	logic                  big [lci_pkg::LANES];
	logic signed [SUMW-1:0] cen [lci_pkg::LANES];
	logic signed [SUMW-1:0] sum [lci_pkg::LANES];
	logic [W-1:0]          res [lci_pkg::LANES];
	logic [lci_pkg::OUT_W-1:0] data_nx;
	logic                  m_tvalid_q;
	logic [lci_pkg::OUT_W-1:0] m_tdata_q;
	logic [1:0]            m_tuser_q;

	assign en = ~m_tvalid_q | m_tready;
	assign s_tready = en;

	assign in_a = s_tdata[W-1:0];
	assign in_b = s_tdata[2*W-1:W];
	assign in_c = s_tdata[3*W-1:2*W];
	assign in_cx = s_tdata[4*W-1:3*W];
	assign in_cy = s_tdata[5*W-1:4*W];
	assign in_r = s_tdata[6*W-2:5*W];
	assign in_ma = in_a[W-1] ? MW'(-in_a) : MW'(in_a);
	assign in_mb = in_b[W-1] ? MW'(-in_b) : MW'(in_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= sqc[lci_pkg::SQRT_CELLS].valid;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pac_s1 <= in_a * in_cx;
			pbc_s1 <= in_b * in_cy;
			sqa_s1 <= in_ma * in_ma;
			sqb_s1 <= in_mb * in_mb;
			r2_s1 <= in_r * in_r;
			c_s1 <= in_c;
			cx_s1 <= in_cx;
			cy_s1 <= in_cy;
			ma_s1 <= in_ma;
			mb_s1 <= in_mb;
			an_s1 <= in_a[W-1];
			az_s1 <= in_a == '0;
			bn_s1 <= in_b[W-1];
			bp_s1 <= ~in_b[W-1] && in_b != '0;
		end
	end

	// line offset relative to the centre
	always_ff @(posedge clk) begin
		if (en) begin
			k_s2 <= KW'(pac_s1) + KW'(pbc_s1) + (KW'(c_s1) <<< lci_pkg::FRAC_BITS);
			r2_s2 <= r2_s1;
			side_s2.ma <= ma_s1;
			side_s2.mb <= mb_s1;
			side_s2.an <= an_s1;
			side_s2.az <= az_s1;
			side_s2.bn <= bn_s1;
			side_s2.bp <= bp_s1;
			side_s2.q <= sqa_s1 + sqb_s1;
			side_s2.cx <= cx_s1;
			side_s2.cy <= cy_s1;
			side_s2.kn <= 1'b0;
		end
	end

	assign km = k_s2[KW-1] ? (KW-1)'(-k_s2) : (KW-1)'(k_s2);

	lci_mul u_mul_k2 (.clk(clk), .en(en), .x(OPW'(km)), .y(OPW'(km)), .p(k2_p));
	lci_mul u_mul_qr (.clk(clk), .en(en), .x(OPW'(side_s2.q)), .y(OPW'(r2_s2)),
		.p(qr2_p));
	lci_mul u_mul_bk (.clk(clk), .en(en), .x(OPW'(side_s2.mb)), .y(OPW'(km)),
		.p(bk_p));
	lci_mul u_mul_ak (.clk(clk), .en(en), .x(OPW'(side_s2.ma)), .y(OPW'(km)),
		.p(ak_p));

	always_comb begin
		side_k = side_s2;
		side_k.kn = k_s2[KW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_k;
			side_s4 <= side_s3;
		end
	end

	// discriminant and the fixed parts of both numerators
	always_comb begin
		diff = qr2_p - k2_p;
		miss = qr2_p < k2_p;
		degen = side_s4.q == '0;
		gpos = side_s4.az ? ~side_s4.bp : ~side_s4.an;
		tvm = bk_p[NW-1:0];
		tum = ak_p[NW-1:0];
		sq_in.valid = v_s4;
		if (degen) begin
			sq_in.status = lci_pkg::ST_DEGEN;
		end else if (miss) begin
			sq_in.status = lci_pkg::ST_MISS;
		end else begin
			sq_in.status = lci_pkg::ST_HIT;
		end
		sq_in.e = diff[EW-1:0];
		sq_in.rem = '0;
		sq_in.root = '0;
		sq_in.tv = (side_s4.bn ^ side_s4.kn) ? signed'(tvm) : -signed'(tvm);
		sq_in.tu = (side_s4.an ^ side_s4.kn) ? signed'(tum) : -signed'(tum);
		sq_in.ma = side_s4.ma;
		sq_in.mb = side_s4.mb;
		sq_in.fneg = side_s4.bp == gpos;
		sq_in.q = side_s4.q;
		sq_in.cx = side_s4.cx;
		sq_in.cy = side_s4.cy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5 <= sq_in;
		end
	end

	always_comb begin
		sqc[0] = sq_s5;
		sqc[0].valid = v_s5;
	end

	for (genvar i = 0; i < lci_pkg::SQRT_CELLS; i++) begin : g_sqrt
		lci_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d     (sqc[i]),
			.q_o   (sqc[i+1])
		);
	end

	lci_mul u_mul_as (.clk(clk), .en(en), .x(OPW'(sqc[lci_pkg::SQRT_CELLS].ma)),
		.y(OPW'(sqc[lci_pkg::SQRT_CELLS].root)), .p(as_p));
	lci_mul u_mul_bs (.clk(clk), .en(en), .x(OPW'(sqc[lci_pkg::SQRT_CELLS].mb)),
		.y(OPW'(sqc[lci_pkg::SQRT_CELLS].root)), .p(bs_p));

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s6 <= sqc[lci_pkg::SQRT_CELLS];
			sq_s7 <= sq_s6;
		end
	end

	// four numerators: first x, first y, second x, second y
	always_comb begin
		as_v = signed'(as_p[NW-1:0]);
		bs_v = sq_s7.fneg ? -signed'(bs_p[NW-1:0]) : signed'(bs_p[NW-1:0]);
		nl[0] = sq_s7.tu + bs_v;
		nl[1] = sq_s7.tv + as_v;
		nl[2] = sq_s7.tu - bs_v;
		nl[3] = sq_s7.tv - as_v;
		dv_in.valid = v_s7;
		dv_in.status = sq_s7.status;
		dv_in.q = sq_s7.q;
		dv_in.cx = sq_s7.cx;
		dv_in.cy = sq_s7.cy;
		for (int i = 0; i < lci_pkg::LANES; i++) begin
			nabs[i] = nl[i][NW-1] ? -nl[i] : nl[i];
			dv_in.lane[i].neg = nl[i][NW-1];
			dv_in.lane[i].num = NMW'(nabs[i]);
			dv_in.lane[i].rem = '0;
			dv_in.lane[i].quot = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s8 <= dv_in;
		end
	end

	always_comb begin
		dvc[0] = dv_s8;
		dvc[0].valid = v_s8;
	end

	for (genvar i = 0; i < lci_pkg::DIV_CELLS; i++) begin : g_div
		lci_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d     (dvc[i]),
			.q_o   (dvc[i+1])
		);
	end

	// floor, add the centre, saturate
	always_comb begin
		for (int i = 0; i < lci_pkg::LANES; i++) begin
			mag[i] = dvc[lci_pkg::DIV_CELLS].lane[i].quot
				+ NMW'(dvc[lci_pkg::DIV_CELLS].lane[i].neg
				&& dvc[lci_pkg::DIV_CELLS].lane[i].rem != '0);
			big[i] = |mag[i][NMW-1:W+2];
			cen[i] = (i % 2 == 0) ? SUMW'(dvc[lci_pkg::DIV_CELLS].cx)
				: SUMW'(dvc[lci_pkg::DIV_CELLS].cy);
			sum[i] = dvc[lci_pkg::DIV_CELLS].lane[i].neg
				? cen[i] - signed'(SUMW'(mag[i][W+1:0]))
				: cen[i] + signed'(SUMW'(mag[i][W+1:0]));
			if (dvc[lci_pkg::DIV_CELLS].status != lci_pkg::ST_HIT) begin
				res[i] = '0;
			end else if (big[i]) begin
				res[i] = dvc[lci_pkg::DIV_CELLS].lane[i].neg ? {1'b1, {(W-1){1'b0}}}
					: {1'b0, {(W-1){1'b1}}};
			end else if (sum[i] > signed'(SUMW'({1'b0, {(W-1){1'b1}}}))) begin
				res[i] = {1'b0, {(W-1){1'b1}}};
			end else if (sum[i] < -signed'(SUMW'({1'b1, {(W-1){1'b0}}}))) begin
				res[i] = {1'b1, {(W-1){1'b0}}};
			end else begin
				res[i] = sum[i][W-1:0];
			end
			data_nx[i*W +: W] = res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= dvc[lci_pkg::DIV_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= data_nx;
			m_tuser_q <= dvc[lci_pkg::DIV_CELLS].status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule
